>>> hw/rtl/efp_pkg.sv
// efp_pkg: shared types and constants of the escape-time fractal pixel core
// holds the register map, the configuration struct and controller/datapath links
// no dependencies
package efp_pkg;

  // image and number formats
  localparam int IMAGE_SIZE = 512;
  localparam int PIX_W      = 9;
  localparam int FRAC_W     = 28;
  localparam int Q_W        = 32;
  localparam int ZOOM_W     = 31;
  localparam int ITER_W     = 10;

  // pixel to plane mapping: 4*zoom*p / IMAGE_SIZE is a right shift
  localparam int MAP_SHIFT  = $clog2(IMAGE_SIZE) - 2;
  localparam int MAP_PROD_W = ZOOM_W + PIX_W;
  localparam int SPAN_W     = MAP_PROD_W - MAP_SHIFT;
  localparam int COORD_W    = SPAN_W + 3;

  // iteration widths: products kept after the 28-bit shift
  localparam int PROD_W = 2 * Q_W;
  localparam int SQ_W   = PROD_W - FRAC_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int NEW_W  = SQ_W + 2;

  localparam logic signed [SUM_W-1:0] ESC_LIMIT = SUM_W'(4) << FRAC_W;

  // colours
  localparam int COLOR_W = 24;
  localparam logic [COLOR_W-1:0] COLOR_ESCAPED = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR_BOUNDED = 24'hFF00FF;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_ZOOM     = 3'd1,
    REG_JULIA_RE = 3'd2,
    REG_JULIA_IM = 3'd3,
    REG_MAX_ITER = 3'd4
  } reg_idx_e;

  localparam logic              MODE_MANDELBROT = 1'b0;
  localparam logic              MODE_JULIA      = 1'b1;
  localparam logic [ZOOM_W-1:0] ZOOM_RESET      = ZOOM_W'(1) << FRAC_W;
  localparam logic [ITER_W-1:0] MAX_ITER_RESET  = ITER_W'(150);

  typedef struct packed {
    logic                    mode;
    logic [ZOOM_W-1:0]       zoom;
    logic signed [Q_W-1:0]   julia_re;
    logic signed [Q_W-1:0]   julia_im;
    logic [ITER_W-1:0]       max_iter;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load_pix;
    logic map;
    logic init;
    logic mul;
    logic step;
    logic load_out;
    logic bnd;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic esc;
    logic ovf;
  } sts_t;

  // clamp a mapped coordinate into Q4.28
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [COORD_W-1:0] v);
    logic fits;
    fits = (&v[COORD_W-1:Q_W-1]) || ~(|v[COORD_W-1:Q_W-1]);
    if (fits) begin
      sat_q = v[Q_W-1:0];
    end else if (v[COORD_W-1]) begin
      sat_q = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      sat_q = {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> hw/rtl/efp_cfg_regs.sv
// efp_cfg_regs: configuration registers behind the APB-style port
// depends on efp_pkg for the register map and cfg_t
module efp_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [efp_pkg::ADDR_W-1:0]  paddr,
  input  logic [efp_pkg::DATA_W-1:0]  pwdata,
  output logic [efp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output efp_pkg::cfg_t               cfg_o
);

  efp_pkg::cfg_t    cfg_q;
  logic             wr_en;
  efp_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = efp_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= efp_pkg::MODE_MANDELBROT;
      cfg_q.zoom     <= efp_pkg::ZOOM_RESET;
      cfg_q.julia_re <= '0;
      cfg_q.julia_im <= '0;
      cfg_q.max_iter <= efp_pkg::MAX_ITER_RESET;
    end else if (wr_en) begin
      case (idx)
        efp_pkg::REG_MODE:     cfg_q.mode     <= pwdata[0];
        efp_pkg::REG_ZOOM:     cfg_q.zoom     <= pwdata[efp_pkg::ZOOM_W-1:0];
        efp_pkg::REG_JULIA_RE: cfg_q.julia_re <= pwdata;
        efp_pkg::REG_JULIA_IM: cfg_q.julia_im <= pwdata;
        efp_pkg::REG_MAX_ITER: cfg_q.max_iter <= pwdata[efp_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    case (idx)
      efp_pkg::REG_MODE:     prdata = efp_pkg::DATA_W'(cfg_q.mode);
      efp_pkg::REG_ZOOM:     prdata = efp_pkg::DATA_W'(cfg_q.zoom);
      efp_pkg::REG_JULIA_RE: prdata = cfg_q.julia_re;
      efp_pkg::REG_JULIA_IM: prdata = cfg_q.julia_im;
      efp_pkg::REG_MAX_ITER: prdata = efp_pkg::DATA_W'(cfg_q.max_iter);
      default:               prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/efp_datapath.sv
// efp_datapath: coordinate mapping, z^2 + c iteration and the output word register
// depends on efp_pkg; driven by efp_ctrl through cmd_t, reports through sts_t
module efp_datapath (
  input  logic                         clk_i,
  input  efp_pkg::cfg_t                cfg_i,
  input  logic [efp_pkg::PIX_W-1:0]    pix_x_i,
  input  logic [efp_pkg::PIX_W-1:0]    pix_y_i,
  input  efp_pkg::cmd_t                cmd_i,
  output efp_pkg::sts_t                sts_o,
  output logic [efp_pkg::PIX_W-1:0]    out_x_o,
  output logic [efp_pkg::PIX_W-1:0]    out_y_o,
  output logic                         bounded_o,
  output logic [efp_pkg::COLOR_W-1:0]  color_o
);

  localparam int QW  = efp_pkg::Q_W;
  localparam int FW  = efp_pkg::FRAC_W;
  localparam int CW  = efp_pkg::COORD_W;
  localparam int SQW = efp_pkg::SQ_W;
  localparam int NW  = efp_pkg::NEW_W;
  localparam int SMW = efp_pkg::SUM_W;

  logic [efp_pkg::PIX_W-1:0]       px_q, py_q;
  logic [efp_pkg::SPAN_W-1:0]      span_x_q, span_y_q;
  logic [efp_pkg::MAP_PROD_W-1:0]  mul_x, mul_y;
  logic signed [CW-1:0]            half, re_w, im_w;
  logic signed [QW-1:0]            pr, pi;
  logic signed [QW-1:0]            z_re_q, z_im_q, c_re_q, c_im_q;
  logic signed [efp_pkg::PROD_W-1:0] prod_rr, prod_ii, prod_ri;
  logic signed [SQW-1:0]           sq_r_q, sq_i_q, p_ri_q;
  logic signed [SMW-1:0]           mag;
  logic signed [NW-1:0]            n_re, n_im;
  logic                            ovf_re, ovf_im;
  logic [efp_pkg::PIX_W-1:0]       out_x_q, out_y_q;
  logic                            out_bnd_q;

  // pixel latch at acceptance
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      px_q <= pix_x_i;
      py_q <= pix_y_i;
    end
  end

  // mapping products zoom * pixel, shifted for the 4/IMAGE_SIZE scale
  assign mul_x = efp_pkg::MAP_PROD_W'(cfg_i.zoom) * efp_pkg::MAP_PROD_W'(px_q);
  assign mul_y = efp_pkg::MAP_PROD_W'(cfg_i.zoom) * efp_pkg::MAP_PROD_W'(py_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.map) begin
      span_x_q <= mul_x[efp_pkg::MAP_PROD_W-1:efp_pkg::MAP_SHIFT];
      span_y_q <= mul_y[efp_pkg::MAP_PROD_W-1:efp_pkg::MAP_SHIFT];
    end
  end

  // plane coordinates, imaginary axis inverted, clamped to Q4.28
  assign half = $signed({4'b0000, cfg_i.zoom, 1'b0});
  assign re_w = $signed({3'b000, span_x_q}) - half;
  assign im_w = half - $signed({3'b000, span_y_q});
  assign pr   = efp_pkg::sat_q(re_w);
  assign pi   = efp_pkg::sat_q(im_w);

  // three parallel products of the current z
  assign prod_rr = z_re_q * z_re_q;
  assign prod_ii = z_im_q * z_im_q;
  assign prod_ri = z_re_q * z_im_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      sq_r_q <= prod_rr[efp_pkg::PROD_W-1:FW];
      sq_i_q <= prod_ii[efp_pkg::PROD_W-1:FW];
      p_ri_q <= prod_ri[efp_pkg::PROD_W-1:FW];
    end
  end

  // escape test on |z|^2 and next z with range check
  assign mag    = SMW'(sq_r_q) + SMW'(sq_i_q);
  assign n_re   = NW'(sq_r_q) - NW'(sq_i_q) + NW'(c_re_q);
  assign n_im   = (NW'(p_ri_q) <<< 1) + NW'(c_im_q);
  assign ovf_re = !((&n_re[NW-1:QW-1]) || ~(|n_re[NW-1:QW-1]));
  assign ovf_im = !((&n_im[NW-1:QW-1]) || ~(|n_im[NW-1:QW-1]));

  assign sts_o.esc = mag > efp_pkg::ESC_LIMIT;
  assign sts_o.ovf = ovf_re || ovf_im;

  // orbit registers: start point by mode, then one update per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      if (cfg_i.mode == efp_pkg::MODE_JULIA) begin
        z_re_q <= pr;
        z_im_q <= pi;
        c_re_q <= cfg_i.julia_re;
        c_im_q <= cfg_i.julia_im;
      end else begin
        z_re_q <= '0;
        z_im_q <= '0;
        c_re_q <= pr;
        c_im_q <= pi;
      end
    end else if (cmd_i.step) begin
      z_re_q <= n_re[QW-1:0];
      z_im_q <= n_im[QW-1:0];
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_x_q   <= px_q;
      out_y_q   <= py_q;
      out_bnd_q <= cmd_i.bnd;
    end
  end

  assign out_x_o   = out_x_q;
  assign out_y_o   = out_y_q;
  assign bounded_o = out_bnd_q;
  assign color_o   = out_bnd_q ? efp_pkg::COLOR_BOUNDED : efp_pkg::COLOR_ESCAPED;

endmodule

>>> hw/rtl/efp_ctrl.sv
// efp_ctrl: sequencing state machine and iteration counter
// depends on efp_pkg for cmd_t and sts_t; commands efp_datapath
module efp_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic                         m_ready_i,
  output logic                         m_valid_o,
  input  logic [efp_pkg::ITER_W-1:0]   max_iter_i,
  input  efp_pkg::sts_t                sts_i,
  output efp_pkg::cmd_t                cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_INIT,
    S_MUL,
    S_EVAL,
    S_DONE
  } state_e;

  state_e                      state_q, state_d;
  logic [efp_pkg::ITER_W-1:0]  cnt_q, cnt_d;
  logic                        bnd_q, bnd_d;
  logic                        m_valid_q, m_valid_d;
  logic                        at_limit, out_free;

  assign at_limit  = (cnt_q == max_iter_i);
  assign out_free  = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    bnd_d     = bnd_q;
    m_valid_d = m_valid_q && !m_ready_i;
    cmd_o     = '0;
    cmd_o.bnd = bnd_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_pix = 1'b1;
          state_d        = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_INIT;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        cnt_d      = '0;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_EVAL;
      end
      S_EVAL: begin
        // escape is only tested after at least one update
        if ((cnt_q != '0) && sts_i.esc) begin
          bnd_d   = 1'b0;
          state_d = S_DONE;
        end else if (at_limit) begin
          bnd_d   = 1'b1;
          state_d = S_DONE;
        end else if (sts_i.ovf) begin
          bnd_d   = 1'b0;
          state_d = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
          cnt_d      = cnt_q + 1'b1;
          state_d    = S_MUL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          m_valid_d      = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      bnd_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      bnd_q     <= bnd_d;
      m_valid_q <= m_valid_d;
    end
  end

  // checks
  a_accept_starts_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == S_MAP))
    else $error("accepted word did not start mapping");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> out_free)
    else $error("result loaded over a word not yet taken");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> m_valid_q)
    else $error("loaded result not presented");

  a_step_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> (cnt_q != max_iter_i))
    else $error("iteration step issued at the limit");

endmodule

>>> hw/rtl/escape_time_fractal_pixel_core.sv
// Escape-time fractal pixel core: one Mandelbrot or Julia verdict per pixel word.
// A new pixel is taken only in the idle state, after the previous verdict is loaded;
// the core runs up to max_iterations steps per pixel.
// Each z^2 + c step uses the three parallel 32x32 multipliers, then the add, range and
// escape logic. The result register frees the input side.
// Reset (rst_ni, asynchronous, active low) clears control state and loads register defaults.
module escape_time_fractal_pixel_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input word: [8:0] pixel_x, [17:9] pixel_y, upper bits unused
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,
  // result word: [8:0] out_x, [17:9] out_y, [18] bounded, [42:19] color, rest zero
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [efp_pkg::ADDR_W-1:0]  paddr,
  input  logic [efp_pkg::DATA_W-1:0]  pwdata,
  output logic [efp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  efp_pkg::cfg_t                 cfg;
  efp_pkg::cmd_t                 cmd;
  efp_pkg::sts_t                 sts;
  logic [efp_pkg::PIX_W-1:0]     out_x, out_y;
  logic                          bounded;
  logic [efp_pkg::COLOR_W-1:0]   color;

  efp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  efp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .max_iter_i (cfg.max_iter),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  efp_datapath u_dp (
    .clk_i     (clk_i),
    .cfg_i     (cfg),
    .pix_x_i   (s_axis_tdata[8:0]),
    .pix_y_i   (s_axis_tdata[17:9]),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_x_o   (out_x),
    .out_y_o   (out_y),
    .bounded_o (bounded),
    .color_o   (color)
  );

  // result packing
  assign m_axis_tdata = {5'b00000, color, bounded, out_y, out_x};

endmodule

>>> bench/tb_escape_time_fractal_pixel_core.sv
// self-checking bench for escape_time_fractal_pixel_core: pixel words in, verdict words out
// predicts each verdict from its own fixed-point orbit model and checks it in order
// depends on efp_pkg and the core rtl
module tb_escape_time_fractal_pixel_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -64'sd2147483648;
  localparam longint ESCAPE_SQ   = longint'(4) << efp_pkg::FRAC_W;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     HOLD_AT     = 100;
  localparam int     HOLD_LEN    = 3000;

  typedef struct packed {
    logic [efp_pkg::PIX_W-1:0] y;
    logic [efp_pkg::PIX_W-1:0] x;
  } pixel_t;

  typedef struct packed {
    logic [efp_pkg::PIX_W-1:0]   x;
    logic [efp_pkg::PIX_W-1:0]   y;
    logic                        bounded;
    logic [efp_pkg::COLOR_W-1:0] color;
  } verdict_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // [8:0] pixel_x, [17:9] pixel_y, upper bits zero
  logic [23:0]                  s_axis_tdata  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // [8:0] out_x, [17:9] out_y, [18] bounded, [42:19] color, rest zero
  logic [47:0]                  m_axis_tdata;
  logic                         psel          = 1'b0;
  logic                         penable       = 1'b0;
  logic                         pwrite        = 1'b0;
  logic [efp_pkg::ADDR_W-1:0]   paddr         = '0;
  logic [efp_pkg::DATA_W-1:0]   pwdata        = '0;
  logic [efp_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  efp_pkg::cfg_t model_cfg;
  pixel_t        pixel_backlog[$];
  verdict_t      pending_verdicts[$];
  int            err_count    = 0;
  int            results_seen = 0;
  int            cycle_count  = 0;

  escape_time_fractal_pixel_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // q4.28 product, floor of the exact 64-bit product
  function automatic longint fix_mul(longint a, longint b);
    return (a * b) >>> efp_pkg::FRAC_W;
  endfunction

  // pixel index onto the plane, clamped into q4.28
  function automatic longint plane_coord(longint zoom, logic [efp_pkg::PIX_W-1:0] p,
                                         bit flip);
    longint span;
    longint half;
    longint v;
    span = (4 * zoom * longint'(p)) / efp_pkg::IMAGE_SIZE;
    half = 2 * zoom;
    v    = flip ? half - span : span - half;
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // escape-time verdict for one pixel under the given settings
  function automatic logic orbit_stays_bounded(efp_pkg::cfg_t c,
                                               logic [efp_pkg::PIX_W-1:0] px,
                                               logic [efp_pkg::PIX_W-1:0] py);
    longint pr, pi, zr, zi, cr, ci, nr, ni;
    pr = plane_coord(longint'(c.zoom), px, 1'b0);
    pi = plane_coord(longint'(c.zoom), py, 1'b1);
    if (c.mode == efp_pkg::MODE_JULIA) begin
      zr = pr;
      zi = pi;
      cr = longint'($signed(c.julia_re));
      ci = longint'($signed(c.julia_im));
    end else begin
      zr = 0;
      zi = 0;
      cr = pr;
      ci = pi;
    end
    for (int i = 0; i < int'(c.max_iter); i++) begin
      nr = fix_mul(zr, zr) - fix_mul(zi, zi) + cr;
      ni = 2 * fix_mul(zr, zi) + ci;
      // leaving the q4.28 range counts as escape
      if (nr > Q_MAX || nr < Q_MIN || ni > Q_MAX || ni < Q_MIN) return 1'b0;
      zr = nr;
      zi = ni;
      if (fix_mul(zr, zr) + fix_mul(zi, zi) > ESCAPE_SQ) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(string what, longint want, longint got);
    err_count++;
    if (err_count <= 10) begin
      $display("mismatch %s: expected 0x%0h got 0x%0h at cycle %0d", what, want, got,
               cycle_count);
    end
  endtask

  // sender: bursts of pixel words with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin : drive_pixels
    logic     taken;
    pixel_t   nxt;
    verdict_t v;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      taken = s_axis_tvalid && s_axis_tready;
      // predict the verdict of the word just taken
      if (taken) begin
        v.x       = s_axis_tdata[efp_pkg::PIX_W-1:0];
        v.y       = s_axis_tdata[2*efp_pkg::PIX_W-1:efp_pkg::PIX_W];
        v.bounded = orbit_stays_bounded(model_cfg, v.x, v.y);
        v.color   = v.bounded ? efp_pkg::COLOR_BOUNDED : efp_pkg::COLOR_ESCAPED;
        pending_verdicts.push_back(v);
      end
      if (!s_axis_tvalid || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          nxt = pixel_backlog.pop_front();
          s_axis_tdata  <= {6'b0, nxt.y, nxt.x};
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random ready runs, plus one long hold-off to back the core up
  bit ready_phase = 1'b0;
  int run_left    = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        ready_phase = ~ready_phase;
        if (ready_phase) begin
          run_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 25);
        end else begin
          run_left = $urandom_range(1, 12);
        end
      end
      run_left--;
      m_axis_tready <= ready_phase;
    end
  end

  // monitor: compare each verdict word with the oldest prediction
  always @(posedge clk_i) begin : check_verdicts
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("unexpected verdict word", 0, m_axis_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[efp_pkg::PIX_W-1:0] !== want.x)
          flag_mismatch("out_x", want.x, m_axis_tdata[efp_pkg::PIX_W-1:0]);
        if (m_axis_tdata[2*efp_pkg::PIX_W-1:efp_pkg::PIX_W] !== want.y)
          flag_mismatch("out_y", want.y, m_axis_tdata[2*efp_pkg::PIX_W-1:efp_pkg::PIX_W]);
        if (m_axis_tdata[2*efp_pkg::PIX_W] !== want.bounded)
          flag_mismatch("bounded", want.bounded, m_axis_tdata[2*efp_pkg::PIX_W]);
        if (m_axis_tdata[2*efp_pkg::PIX_W+efp_pkg::COLOR_W:2*efp_pkg::PIX_W+1] !== want.color)
          flag_mismatch("color", want.color,
                        m_axis_tdata[2*efp_pkg::PIX_W+efp_pkg::COLOR_W:2*efp_pkg::PIX_W+1]);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic queue_pixel(int x, int y);
    pixel_t p;
    p.x = efp_pkg::PIX_W'(x);
    p.y = efp_pkg::PIX_W'(y);
    pixel_backlog.push_back(p);
  endtask

  // wait until every word is taken and every verdict is back
  task automatic settle();
    while (pixel_backlog.size() != 0 || s_axis_tvalid || pending_verdicts.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic apb_write(efp_pkg::reg_idx_e idx, logic [efp_pkg::DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= efp_pkg::ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write the full register set once the core is idle
  task automatic program_settings(efp_pkg::cfg_t c);
    settle();
    apb_write(efp_pkg::REG_MODE, efp_pkg::DATA_W'(c.mode));
    apb_write(efp_pkg::REG_ZOOM, efp_pkg::DATA_W'(c.zoom));
    apb_write(efp_pkg::REG_JULIA_RE, c.julia_re);
    apb_write(efp_pkg::REG_JULIA_IM, c.julia_im);
    apb_write(efp_pkg::REG_MAX_ITER, efp_pkg::DATA_W'(c.max_iter));
    model_cfg = c;
  endtask

  // stimulus sequence
  initial begin : stimulus
    efp_pkg::cfg_t c;
    int            count;
    model_cfg.mode     = efp_pkg::MODE_MANDELBROT;
    model_cfg.zoom     = efp_pkg::ZOOM_RESET;
    model_cfg.julia_re = '0;
    model_cfg.julia_im = '0;
    model_cfg.max_iter = efp_pkg::MAX_ITER_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: corners, centre, the real axis and the top edge
    queue_pixel(0, 0);
    queue_pixel(511, 511);
    queue_pixel(0, 511);
    queue_pixel(511, 0);
    queue_pixel(256, 256);
    queue_pixel(128, 256);
    queue_pixel(384, 256);
    queue_pixel(0, 256);
    queue_pixel(256, 0);
    queue_pixel(1, 1);
    queue_pixel(510, 510);
    queue_pixel(170, 341);

    // zero iteration limit: always bounded
    c = model_cfg;
    c.max_iter = '0;
    program_settings(c);
    queue_pixel(511, 511);
    queue_pixel(0, 0);

    // zero zoom: every pixel lands on the origin
    c.max_iter = efp_pkg::MAX_ITER_RESET;
    c.zoom     = '0;
    program_settings(c);
    queue_pixel(0, 0);
    queue_pixel(511, 511);

    // julia from the origin with extreme constants
    c.mode     = efp_pkg::MODE_JULIA;
    c.julia_re = 32'sh7FFF_FFFF;
    c.julia_im = 32'sh8000_0000;
    program_settings(c);
    queue_pixel(0, 0);
    queue_pixel(300, 200);

    // widest view: mapping saturates and the orbit overflows
    c.zoom     = {efp_pkg::ZOOM_W{1'b1}};
    c.julia_re = '0;
    c.julia_im = '0;
    program_settings(c);
    queue_pixel(0, 0);
    queue_pixel(511, 511);
    queue_pixel(256, 256);

    // random phases, each under fresh settings
    for (int p = 0; p < 13; p++) begin
      c.mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       c.zoom = {efp_pkg::ZOOM_W{1'b1}};
        1:       c.zoom = efp_pkg::ZOOM_W'(1);
        default: c.zoom = efp_pkg::ZOOM_W'($urandom_range(32'h0100_0000, 32'h2000_0000));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        c.julia_re = $urandom;
        c.julia_im = $urandom;
      end else begin
        c.julia_re = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
        c.julia_im = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      end
      c.max_iter = ($urandom_range(0, 4) == 0) ? efp_pkg::MAX_ITER_RESET
                                               : efp_pkg::ITER_W'($urandom_range(1, 48));
      count = 60;
      // pinned extremes in the first phases
      case (p)
        0: begin
          c.mode     = efp_pkg::MODE_MANDELBROT;
          c.zoom     = {efp_pkg::ZOOM_W{1'b1}};
          c.julia_re = 32'sh8000_0000;
          c.julia_im = 32'sh7FFF_FFFF;
          c.max_iter = efp_pkg::ITER_W'(1);
        end
        1: begin
          c.mode = efp_pkg::MODE_JULIA;
          c.zoom = efp_pkg::ZOOM_W'(1);
        end
        2: begin
          c.zoom     = efp_pkg::ZOOM_W'($urandom_range(32'h0800_0000, 32'h1800_0000));
          c.max_iter = {efp_pkg::ITER_W{1'b1}};
          count      = 8;
        end
        default: ;
      endcase
      program_settings(c);
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 8) == 0) begin
          queue_pixel($urandom_range(0, 1) * 511, $urandom_range(0, 1) * 511);
        end else begin
          queue_pixel($urandom_range(0, 511), $urandom_range(0, 511));
        end
      end
    end

    // drain
    settle();
    repeat (2 * int'(model_cfg.max_iter) + 10) @(posedge clk_i);
    if (pending_verdicts.size() != 0)
      flag_mismatch("verdicts never delivered", 0, pending_verdicts.size());
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/efp_pkg.sv
hw/rtl/efp_cfg_regs.sv
hw/rtl/efp_datapath.sv
hw/rtl/efp_ctrl.sv
hw/rtl/escape_time_fractal_pixel_core.sv
bench/tb_escape_time_fractal_pixel_core.sv
